[sv/bipl_pkg.sv]
// bipl_pkg: shared widths, codes and interface structs of the perceptron layer
// no dependencies; imported by the lane, merge and top-level modules
`timescale 1ns / 1ps

package bipl_pkg;

   // fixed widths of the beat fields
   localparam int IDX_BITS   = 6;
   localparam int VALUE_BITS = 16;
   localparam int VEC_BITS   = 64;
   localparam int CNT_BITS   = 7;
   localparam int MODE_BITS  = 2;

   // parameter defaults
   localparam int DEF_MAX_INPUTS  = 64;
   localparam int DEF_MAX_OUTPUTS = 64;
   localparam int DEF_WEIGHT_BITS = 16;

   // request mode codes
   localparam logic [MODE_BITS-1:0] MODE_WEIGHT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_BIAS   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_EVAL   = 2'd2;

   // register indexes
   localparam logic REG_INPUTS  = 1'b0;
   localparam logic REG_OUTPUTS = 1'b1;

   // per-lane weight column control
   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_row;
      logic [IDX_BITS-1:0] rd_row;
   } lane_ctl_type;

   // bias write control
   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] row;
   } bias_wr_type;

   // neuron tag travelling with the merge pipeline
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [IDX_BITS-1:0] row;
   } tag_type;

   // one neuron decision leaving the merge stage
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [IDX_BITS-1:0] row;
      logic                bit_val;
   } step_type;

endpackage

[sv/bipl_lane.sv]
// bipl_lane: one input column of the weight store plus the input-bit gate
// depends on bipl_pkg
`timescale 1ns / 1ps

module bipl_lane
   import bipl_pkg::*;
#(
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                   clock,
   input  lane_ctl_type           ctl,
   input  logic [VALUE_BITS-1:0]  wr_value,
   input  logic                   use_bit,
   output logic [WEIGHT_BITS-1:0] weight_out
);

   localparam int ROW_BITS = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

   logic [WEIGHT_BITS-1:0] mem [MAX_OUTPUTS];
   logic [WEIGHT_BITS-1:0] rd_ff;
   logic signed [31:0]     value_ext;

   // wrap or sign-extend to the stored weight width
   assign value_ext = 32'(signed'(wr_value));

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_row[ROW_BITS-1:0]] <= value_ext[WEIGHT_BITS-1:0];
      end
      rd_ff <= mem[ctl.rd_row[ROW_BITS-1:0]];
   end

   // input bit clear or unused: contributes nothing
   assign weight_out = use_bit ? rd_ff : '0;

endmodule

[sv/bipl_merge.sv]
// bipl_merge: registered adder tree over the lanes, bias store and step decision
// depends on bipl_pkg
`timescale 1ns / 1ps

module bipl_merge
   import bipl_pkg::*;
#(
   parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bias_wr_type                             bias_wr,
   input  logic [VALUE_BITS-1:0]                   wr_value,
   input  tag_type                                 issue,
   input  logic [MAX_INPUTS-1:0][WEIGHT_BITS-1:0]  lane_weights,
   output step_type                                step
);

   localparam int LEVELS   = $clog2(MAX_INPUTS);
   localparam int LEAF_CNT = 1 << LEVELS;
   localparam int NODE_CNT = 2 * LEAF_CNT - 1;
   localparam int WIDE     = (WEIGHT_BITS > VALUE_BITS) ? WEIGHT_BITS : VALUE_BITS;
   localparam int SUM_BITS = WIDE + LEVELS + 2;
   localparam int DEPTH    = LEVELS + 2;
   localparam int ROW_BITS = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

   logic [VALUE_BITS-1:0]      bias_mem [MAX_OUTPUTS];
   logic [VALUE_BITS-1:0]      bias_rd_ff;
   logic [VALUE_BITS-1:0]      bias_dly_ff [LEVELS+1];
   logic signed [SUM_BITS-1:0] node_ff [NODE_CNT];
   tag_type                    tag_ff [DEPTH];
   logic signed [SUM_BITS-1:0] total;

   // bias store, read alongside the weight columns
   always_ff @(posedge clock) begin
      if (bias_wr.wr_en) begin
         bias_mem[bias_wr.row[ROW_BITS-1:0]] <= wr_value;
      end
      bias_rd_ff <= bias_mem[issue.row[ROW_BITS-1:0]];
   end

   // bias delay matches the tree depth
   always_ff @(posedge clock) begin
      bias_dly_ff[0] <= bias_rd_ff;
      for (int k = 1; k <= LEVELS; k++) begin
         bias_dly_ff[k] <= bias_dly_ff[k-1];
      end
   end

   // leaves of the heap-ordered tree
   for (genvar j = 0; j < LEAF_CNT; j++) begin : g_leaf
      if (j < MAX_INPUTS) begin : g_used
         always_ff @(posedge clock) begin
            node_ff[LEAF_CNT-1+j] <= SUM_BITS'(signed'(lane_weights[j]));
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_ff[LEAF_CNT-1+j] <= '0;
         end
      end
   end

   // inner nodes, one register level each
   for (genvar k = 0; k < LEAF_CNT - 1; k++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[k] <= node_ff[2*k+1] + node_ff[2*k+2];
      end
   end

   // tag pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            tag_ff[k] <= '0;
         end
      end else begin
         tag_ff[0] <= issue;
         for (int k = 1; k < DEPTH; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign total = node_ff[0] + SUM_BITS'(signed'(bias_dly_ff[LEVELS]));

   always_comb begin
      step.valid   = tag_ff[DEPTH-1].valid;
      step.last    = tag_ff[DEPTH-1].last;
      step.row     = tag_ff[DEPTH-1].row;
      step.bit_val = ~total[SUM_BITS-1];
   end

`ifndef SYNTHESIS
   a_last_has_valid: assert property (@(posedge clock) disable iff (reset)
      step.last |-> step.valid)
      else $error("merge: last flag without valid neuron");

   a_issue_row_range: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> (32'(issue.row) < MAX_OUTPUTS))
      else $error("merge: neuron row beyond store depth");
`endif

endmodule

[sv/binary_input_perceptron_layer.sv]
// binary_input_perceptron_layer: top level, request decode, neuron sequencer, result register
// depends on bipl_pkg, bipl_lane, bipl_merge
`timescale 1ns / 1ps

// usage
//   req_* beats carry a mode: weight write, bias write or evaluate; mode three is dropped
//   writes give no rsp beat; an evaluate gives exactly one rsp beat
//   csr_* writes set the input and output counts in use (values above max saturate)
//   csr writes must be made only while no evaluate is in flight; the block does not enforce it
// evaluate and write flow
//   evaluate: one neuron per cycle, every lane reads its weight column at that row,
//   so the neuron count sets the time; rsp_valid rises once the last neuron
//   decision has left the tree and the rsp register is free
//   weight and bias writes are taken one per cycle while idle
//   req_stall is high while an evaluate runs
// reset
//   clears the sequencer and valids, counts go to their maximum; weight and
//   bias stores keep garbage until written
// receiver stall
//   the finished vector waits in the rsp register; writes are still taken, and
//   a following evaluate holds its result internally until the register frees

module binary_input_perceptron_layer
   import bipl_pkg::*;
#(
   parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MODE_BITS-1:0]  req_mode,
   input  logic [IDX_BITS-1:0]   req_in_index,
   input  logic [IDX_BITS-1:0]   req_out_index,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [VEC_BITS-1:0]   req_input_bits,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VEC_BITS-1:0]   rsp_output_bits,
   // register writes
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CNT_BITS-1:0]   csr_wr_data
);

   localparam int ROW_BITS = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [CNT_BITS-1:0]   ins_ff, ins_in;
   logic [CNT_BITS-1:0]   outs_ff, outs_in;
   logic [MAX_INPUTS-1:0] mask_ff, mask_in;
   logic [VEC_BITS-1:0]   acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VEC_BITS-1:0]   rsp_bits_ff, rsp_bits_in;

   logic                  req_take;
   logic                  wr_weight;
   logic                  wr_bias;
   logic                  eval_take;
   logic                  row_last;
   logic                  rsp_free;
   logic [VEC_BITS-1:0]   out_use_mask;
   tag_type               issue;
   bias_wr_type           bias_wr;
   step_type              step;
   lane_ctl_type          lane_ctl [MAX_INPUTS];
   logic [MAX_INPUTS-1:0][WEIGHT_BITS-1:0] lane_weights;

   // request decode
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign wr_weight = req_take && (req_mode == MODE_WEIGHT)
                      && (32'(req_in_index) < MAX_INPUTS)
                      && (32'(req_out_index) < MAX_OUTPUTS);
   assign wr_bias   = req_take && (req_mode == MODE_BIAS)
                      && (32'(req_out_index) < MAX_OUTPUTS);
   assign eval_take = req_take && (req_mode == MODE_EVAL);

   assign row_last = ((CNT_BITS'(row_ff) + CNT_BITS'(1)) == outs_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // neurons beyond the count in use read as zero
   always_comb begin
      for (int o = 0; o < VEC_BITS; o++) begin
         out_use_mask[o] = (o < 32'(outs_ff));
      end
   end

   // register writes, saturated to the design maximum
   always_comb begin
      ins_in  = ins_ff;
      outs_in = outs_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_INPUTS: begin
               ins_in = (32'(csr_wr_data) > MAX_INPUTS) ? CNT_BITS'(MAX_INPUTS)
                                                        : csr_wr_data;
            end
            REG_OUTPUTS: begin
               outs_in = (32'(csr_wr_data) > MAX_OUTPUTS) ? CNT_BITS'(MAX_OUTPUTS)
                                                          : csr_wr_data;
            end
            default: begin
               ins_in = ins_ff;
            end
         endcase
      end
   end

   // gated input vector captured at the evaluate beat
   always_comb begin
      for (int i = 0; i < MAX_INPUTS; i++) begin
         mask_in[i] = eval_take ? (req_input_bits[i] && (i < 32'(ins_ff))) : mask_ff[i];
      end
   end

   // neuron sequencer
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      acc_in   = acc_ff;
      issue    = '0;
      case (state_ff)
         S_IDLE: begin
            if (eval_take) begin
               row_in   = '0;
               acc_in   = '0;
               state_in = (outs_ff == '0) ? S_DONE : S_ISSUE;
            end
         end
         S_ISSUE: begin
            issue.valid = 1'b1;
            issue.last  = row_last;
            issue.row   = IDX_BITS'(row_ff);
            if (row_last) begin
               state_in = S_DRAIN;
            end else begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end
         S_DRAIN: begin
            if (step.valid && step.last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // collect neuron decisions as they leave the tree
      if (step.valid) begin
         acc_in[step.row] = step.bit_val;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_bits_in  = rsp_bits_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in  = acc_ff & out_use_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         ins_ff       <= CNT_BITS'(MAX_INPUTS);
         outs_ff      <= CNT_BITS'(MAX_OUTPUTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         ins_ff       <= ins_in;
         outs_ff      <= outs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      acc_ff      <= acc_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_output_bits = rsp_bits_ff;

   // one lane per input column
   for (genvar i = 0; i < MAX_INPUTS; i++) begin : g_lane
      always_comb begin
         lane_ctl[i].wr_en  = wr_weight && (req_in_index == IDX_BITS'(i));
         lane_ctl[i].wr_row = req_out_index;
         lane_ctl[i].rd_row = issue.row;
      end

      bipl_lane #(
         .MAX_OUTPUTS (MAX_OUTPUTS),
         .WEIGHT_BITS (WEIGHT_BITS)
      ) u_lane (
         .clock      (clock),
         .ctl        (lane_ctl[i]),
         .wr_value   (req_value),
         .use_bit    (mask_ff[i]),
         .weight_out (lane_weights[i])
      );
   end

   assign bias_wr.wr_en = wr_bias;
   assign bias_wr.row   = req_out_index;

   // adder tree, bias and step decision
   bipl_merge #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_OUTPUTS (MAX_OUTPUTS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .bias_wr      (bias_wr),
      .wr_value     (req_value),
      .issue        (issue),
      .lane_weights (lane_weights),
      .step         (step)
   );

`ifndef SYNTHESIS
   a_step_in_eval: assert property (@(posedge clock) disable iff (reset)
      step.valid |-> ((state_ff == S_ISSUE) || (state_ff == S_DRAIN)))
      else $error("top: neuron decision outside an evaluation");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_output_bits & ~out_use_mask) == '0))
      else $error("top: result bit set beyond neurons in use");

   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      eval_take |=> (state_ff != S_IDLE))
      else $error("top: evaluate beat did not start the sequencer");
`endif

endmodule

[tb/binary_input_perceptron_layer_tb.sv]
// binary_input_perceptron_layer_tb: self-checking bench for the binary-input perceptron layer
// sends weight, bias and evaluate beats, predicts each output vector and checks the rsp beats
// depends on bipl_pkg and binary_input_perceptron_layer
`timescale 1ns / 1ps

module binary_input_perceptron_layer_tb;
   import bipl_pkg::*;

   localparam int N_IN  = DEF_MAX_INPUTS;
   localparam int N_OUT = DEF_MAX_OUTPUTS;

   // mode code with no operation behind it, the block drops it
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   // margin after the owed vectors for the pipe to run empty
   localparam int SETTLE_CYCLES = 100;
   // cycles with no beat on either channel before the run is called hung
   localparam int IDLE_LIMIT    = 2000;
   // random beats that the block acts on, spread over the phases
   localparam int RANDOM_ITEMS  = 560;
   localparam int PHASES        = 8;
   // low neurons whose weight rows are written in full
   localparam int FULL_ROWS     = 4;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [MODE_BITS-1:0]  req_mode;
   logic [IDX_BITS-1:0]   req_in_index;
   logic [IDX_BITS-1:0]   req_out_index;
   logic [VALUE_BITS-1:0] req_value;
   logic [VEC_BITS-1:0]   req_input_bits;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [VEC_BITS-1:0]   rsp_output_bits;
   logic                  csr_wr_en;
   logic                  csr_index;
   logic [CNT_BITS-1:0]   csr_wr_data;

   // bench copy of the layer: weights, biases and the counts in use
   logic signed [VALUE_BITS-1:0] weight_mem [N_OUT][N_IN];
   logic signed [VALUE_BITS-1:0] bias_mem [N_OUT];
   // weights written so far; an evaluate only sets input bits backed by them
   bit                           weight_set [N_OUT][N_IN];
   int                           inputs_used;
   int                           outputs_used;

   // output vectors still owed by the block, oldest first
   logic [VEC_BITS-1:0] pending_vectors [$];
   logic [VEC_BITS-1:0] owed_vector;
   int                  error_count = 0;
   int                  idle_cycles = 0;
   // when set, neither side inserts idle cycles
   bit                  quiet = 1'b0;

   always #4 clock = ~clock;

   binary_input_perceptron_layer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_in_index    (req_in_index),
      .req_out_index   (req_out_index),
      .req_value       (req_value),
      .req_input_bits  (req_input_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_output_bits (rsp_output_bits),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // step activation per neuron in use: bias plus the weights of the set inputs,
   // bit set when the sum is not negative; 64-bit sum never wraps
   function automatic logic [VEC_BITS-1:0] predict_vector(input logic [VEC_BITS-1:0] bits);
      logic [VEC_BITS-1:0] fired;
      longint              acc;
      fired = '0;
      for (int o = 0; o < outputs_used; o++) begin
         acc = bias_mem[o];
         for (int i = 0; i < inputs_used; i++) begin
            if (bits[i]) acc += weight_mem[o][i];
         end
         if (acc >= 0) fired[o] = 1'b1;
      end
      return fired;
   endfunction

   // inputs in use whose weight exists for every neuron in use;
   // bits above the inputs in use are ignored by the block and stay free
   function automatic logic [VEC_BITS-1:0] usable_bits();
      logic [VEC_BITS-1:0] m;
      m = '1;
      for (int i = 0; i < inputs_used; i++) begin
         for (int o = 0; o < outputs_used; o++) begin
            if (!weight_set[o][i]) m[i] = 1'b0;
         end
      end
      return m;
   endfunction

   // ---------------------------------------------------------------------------
   // random field values
   // ---------------------------------------------------------------------------

   // extremes, values near zero and full-range values
   function automatic logic [VALUE_BITS-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return VALUE_BITS'($urandom_range(0, 16) - 8);
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // empty, full, sparse and dense input vectors
   function automatic logic [VEC_BITS-1:0] rand_bits();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // one req beat: optional idle gap, present at the falling edge, hold until taken;
   // valid stays high afterwards so back-to-back beats need no second assignment
   task automatic send_beat(input logic [MODE_BITS-1:0]  mode,
                            input logic [IDX_BITS-1:0]   in_idx,
                            input logic [IDX_BITS-1:0]   out_idx,
                            input logic [VALUE_BITS-1:0] value,
                            input logic [VEC_BITS-1:0]   bits);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_in_index   <= in_idx;
      req_out_index  <= out_idx;
      req_value      <= value;
      req_input_bits <= bits;
      do @(posedge clock); while (req_stall);
      // beat taken at this edge, update the bench copy in order
      case (mode)
         MODE_WEIGHT: begin
            weight_mem[out_idx][in_idx] = value;
            weight_set[out_idx][in_idx] = 1'b1;
         end
         MODE_BIAS:   bias_mem[out_idx] = value;
         MODE_EVAL:   pending_vectors.push_back(predict_vector(bits));
         default:     ;
      endcase
   endtask

   // unused fields of each beat carry random noise
   task automatic write_weight(input int in_pos, input int neuron,
                               input logic [VALUE_BITS-1:0] value);
      send_beat(MODE_WEIGHT, IDX_BITS'(in_pos), IDX_BITS'(neuron), value, rand_bits());
   endtask

   task automatic write_bias(input int neuron, input logic [VALUE_BITS-1:0] value);
      send_beat(MODE_BIAS, IDX_BITS'($urandom), IDX_BITS'(neuron), value, rand_bits());
   endtask

   task automatic evaluate(input logic [VEC_BITS-1:0] bits);
      send_beat(MODE_EVAL, IDX_BITS'($urandom), IDX_BITS'($urandom), VALUE_BITS'($urandom),
                bits & usable_bits());
   endtask

   // drop valid, wait for every owed vector, then let the pipe run empty
   task automatic drain_results(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_vectors.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // one register write, counts above the store size saturate
   task automatic write_count(input logic idx, input logic [CNT_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == REG_INPUTS) inputs_used = (data > N_IN) ? N_IN : data;
      else outputs_used = (data > N_OUT) ? N_OUT : data;
   endtask

   // counts only change with the block idle
   task automatic set_counts(input int n_in, input int n_out);
      drain_results(SETTLE_CYCLES);
      write_count(REG_INPUTS, CNT_BITS'(n_in));
      write_count(REG_OUTPUTS, CNT_BITS'(n_out));
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------

   // receiver stalls ahead of each beat it takes, for a random hold unless quiet is set
   initial begin : rsp_pacer
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 4);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // every rsp beat against the oldest owed vector
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vectors.size() == 0) begin
            $display("%0t ns: rsp beat with nothing owed, expected none, actual %h",
                     $time, rsp_output_bits);
            error_count++;
         end else begin
            owed_vector = pending_vectors.pop_front();
            if (rsp_output_bits !== owed_vector) begin
               $display("%0t ns: output_bits mismatch, expected %h, actual %h",
                        $time, owed_vector, rsp_output_bits);
               error_count++;
            end
         end
      end
   end

   // hang guard: cycles with no beat taken on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no beat for %0d cycles", $time, idle_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // every bias, the low rows in full and a few columns of the other rows;
   // row one at the positive extreme, row two at the negative extreme
   task automatic test_fill_store();
      bit fill;
      for (int o = 0; o < N_OUT; o++) begin
         // upper half goes without idle cycles
         quiet = (o >= N_OUT / 2);
         if (o == 1) write_bias(o, 16'h7FFF);
         else if (o == 2) write_bias(o, 16'h8000);
         else write_bias(o, rand_value());
         for (int i = 0; i < N_IN; i++) begin
            fill = (o < FULL_ROWS) || (i == 0) || (i == 1) || (i == N_IN / 2)
                   || (i == N_IN - 1);
            if (fill) begin
               if (o == 1) write_weight(i, o, 16'h7FFF);
               else if (o == 2) write_weight(i, o, 16'h8000);
               else write_weight(i, o, rand_value());
            end
         end
      end
      quiet = 1'b0;
   endtask

   // counts at their reset value, empty and full vectors, dropped mode
   task automatic test_reset_counts();
      evaluate('0);
      evaluate('1);
      send_beat(MODE_UNUSED, '1, '1, 16'hFFFF, '1);
      evaluate(rand_bits());
      evaluate({$urandom, $urandom});
   endtask

   // sum landing exactly on zero fires, one below does not
   task automatic test_exact_threshold();
      write_weight(0, 0, 16'sd100);
      write_weight(1, 0, -16'sd30);
      write_bias(0, -16'sd70);
      evaluate(64'h3);
      // two inputs in use: the upper input bits must not count
      set_counts(2, N_OUT);
      evaluate('1);
      write_bias(0, -16'sd71);
      evaluate('1);
   endtask

   // zero counts, single neuron, saturating counts and a random pair
   task automatic test_count_extremes();
      for (int k = 0; k < 7; k++) begin
         case (k)
            0:       set_counts(0, N_OUT);     // bias alone decides
            1:       set_counts(N_IN, 0);      // vector always zero
            2:       set_counts(1, 1);
            3:       set_counts(127, 127);     // both saturate
            4:       set_counts(65, 100);
            5:       set_counts(N_IN, FULL_ROWS); // full rows, sums at both extremes
            default: set_counts($urandom_range(1, 63), $urandom_range(1, 63));
         endcase
         evaluate('1);
         evaluate(rand_bits());
      end
   endtask

   // mixed traffic in phases with a new pair of counts each
   task automatic test_random_traffic();
      int pick;
      int taken;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase % 3 == 2) set_counts($urandom_range(0, 127), $urandom_range(0, 127));
         else if (phase % 2 == 1) set_counts($urandom_range(1, 64), $urandom_range(1, FULL_ROWS));
         else set_counts($urandom_range(1, 64), $urandom_range(1, 64));
         // one phase runs with no idle cycles on either side
         quiet = (phase == 3);
         taken = 0;
         while (taken < RANDOM_ITEMS / PHASES) begin
            // sender holds off until the block has caught up
            if (phase == 5 && taken == RANDOM_ITEMS / PHASES / 2) drain_results(0);
            pick = $urandom_range(0, 19);
            if (pick < 10) evaluate(rand_bits());
            else if (pick < 16) write_weight($urandom, $urandom, rand_value());
            else if (pick < 19) write_bias($urandom, rand_value());
            else send_beat(MODE_UNUSED, IDX_BITS'($urandom), IDX_BITS'($urandom),
                           VALUE_BITS'($urandom), rand_bits());
            // dropped beats do not count
            if (pick < 19) taken++;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_WEIGHT;
      req_in_index   = '0;
      req_out_index  = '0;
      req_value      = '0;
      req_input_bits = '0;
      csr_wr_en      = 1'b0;
      csr_index      = REG_INPUTS;
      csr_wr_data    = '0;
      inputs_used    = N_IN;
      outputs_used   = N_OUT;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_store();
      test_reset_counts();
      test_exact_threshold();
      test_count_extremes();
      test_random_traffic();

      // nothing owed, then a margin for stray beats
      drain_results(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
sv/bipl_pkg.sv
sv/bipl_lane.sv
sv/bipl_merge.sv
sv/binary_input_perceptron_layer.sv
tb/binary_input_perceptron_layer_tb.sv
